### rtl/tlpt_pkg.sv
// Shared types, sizes and codes for the two-level page table manager.
// No dependencies; the core refers to it by scoped names, the sim files import it.
`timescale 1ns / 1ps

package tlpt_pkg;

    // Sizes
    localparam int DIRECTORY_COUNT   = 4;
    localparam int TABLE_SLOTS       = 16;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int DIR_DEPTH  = DIRECTORY_COUNT * ENTRIES_PER_TABLE;
    localparam int DIR_AW     = $clog2(DIR_DEPTH);
    localparam int LEAF_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
    localparam int LEAF_W     = 36;
    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NEXT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int CLR_LEN    = (DIR_DEPTH > LEAF_DEPTH) ? DIR_DEPTH : LEAF_DEPTH;
    localparam int CLR_W      = $clog2(CLR_LEN);

    typedef logic [DIR_AW-1:0]  t_dir_addr;
    typedef logic [LEAF_AW-1:0] t_leaf_addr;
    typedef logic [LEAF_W-1:0]  t_leaf;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [NEXT_W-1:0]  t_next;
    typedef logic [CLR_W-1:0]   t_clr;
    typedef logic [CLR_W:0]     t_clr_ext;

    // Directory entry; writable is implied by present and not stored
    typedef struct packed {
        t_slot slot;
        logic  user;
        logic  present;
    } t_dir_ent;

    localparam int DIR_W = $bits(t_dir_ent);

    localparam logic [2:0] DIR_COUNT_LIM  = 3'(DIRECTORY_COUNT);
    localparam t_next      SLOT_LIM       = t_next'(TABLE_SLOTS);
    localparam t_clr       CLR_LAST       = t_clr'(CLR_LEN - 1);
    localparam t_clr_ext   CLR_DIR_LIM    = t_clr_ext'(DIR_DEPTH);
    localparam t_clr_ext   CLR_LEAF_LIM   = t_clr_ext'(LEAF_DEPTH);
    localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;

    // Operation codes
    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT    = 2'd2;

    // Control sequencer, one-hot
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIR   = 4'b0100,
        S_LEAF  = 4'b1000
    } t_state;

endpackage

### rtl/tlpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlpt_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/two_level_page_table_manager_core.sv
// Two-level page table manager: directory store, leaf store, slot allocator.
// Depends on tlpt_pkg and tlpt_ram.
// Timing: map, unmap, bad directory and unused codes strobe a result from the
//   registered result word after S_DIR; translate with a present directory
//   entry strobes after S_LEAF. A new word is taken only back in S_IDLE, after
//   the dependent directory read then leaf read/write on the synchronous RAMs.
// Reset: a clearing sweep over CLR_LEN (8192) addresses zeroes both stores with
//   busy held high; the receiver cannot stall, results are never held back.
`timescale 1ns / 1ps

module two_level_page_table_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_virtual_address,
    input  logic [35:0] i_physical_address,
    input  logic [11:0] i_entry_flags,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_translated_address
);

    // Sequencer and allocator state
    tlpt_pkg::t_state r_state, n_state;
    tlpt_pkg::t_clr   r_clr, n_clr;
    tlpt_pkg::t_next  r_next, n_next;

    // Request word held while it is worked on
    logic [1:0]  r_op;
    logic [31:0] r_va;
    logic [35:0] r_pa;
    logic [11:0] r_flags;

    // Result word
    logic        r_strobe, n_strobe;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_addr, n_addr;

    // Memory ports
    logic                    dir_we, dir_re;
    tlpt_pkg::t_dir_addr     dir_waddr, dir_raddr;
    tlpt_pkg::t_dir_ent      dir_wdata;
    logic [tlpt_pkg::DIR_W-1:0] dir_rdata;
    tlpt_pkg::t_dir_ent      w_dent;

    logic                    leaf_we, leaf_re;
    tlpt_pkg::t_leaf_addr    leaf_waddr, leaf_raddr;
    tlpt_pkg::t_leaf         leaf_wdata, leaf_rdata;

    logic                    w_dir_ok;
    tlpt_pkg::t_leaf_addr    w_leaf_addr;
    tlpt_pkg::t_leaf_addr    w_new_leaf_addr;
    tlpt_pkg::t_leaf         w_map_data;

    tlpt_ram #(
        .DEPTH (tlpt_pkg::DIR_DEPTH),
        .WIDTH (tlpt_pkg::DIR_W)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    tlpt_ram #(
        .DEPTH (tlpt_pkg::LEAF_DEPTH),
        .WIDTH (tlpt_pkg::LEAF_W)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_re    (leaf_re),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rdata)
    );

    assign w_dent   = tlpt_pkg::t_dir_ent'(dir_rdata);
    // Directory select beyond the directory count means no directory at all
    assign w_dir_ok = ({1'b0, r_va[31:30]} < tlpt_pkg::DIR_COUNT_LIM);

    // Leaf position under the existing entry, and under the slot about to be handed out
    assign w_leaf_addr     = tlpt_pkg::t_leaf_addr'({w_dent.slot, r_va[20:12]});
    assign w_new_leaf_addr = tlpt_pkg::t_leaf_addr'({tlpt_pkg::t_slot'(r_next), r_va[20:12]});
    assign w_map_data      = r_pa | {24'd0, r_flags};

    assign busy = (r_state != tlpt_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_next   = r_next;
        n_strobe = 1'b0;
        n_status = r_status;
        n_addr   = r_addr;

        dir_we     = 1'b0;
        dir_waddr  = tlpt_pkg::t_dir_addr'({r_va[31:30], r_va[29:21]});
        dir_wdata  = '0;
        dir_re     = 1'b0;
        dir_raddr  = tlpt_pkg::t_dir_addr'({i_virtual_address[31:30],
                                             i_virtual_address[29:21]});
        leaf_we    = 1'b0;
        leaf_waddr = w_leaf_addr;
        leaf_wdata = '0;
        leaf_re    = 1'b0;
        leaf_raddr = w_leaf_addr;

        case (r_state)
            tlpt_pkg::S_CLEAR: begin
                // Sweep both stores to zero, one entry per cycle in each store up to its depth
                dir_we     = ({1'b0, r_clr} < tlpt_pkg::CLR_DIR_LIM);
                dir_waddr  = tlpt_pkg::t_dir_addr'(r_clr);
                leaf_we    = ({1'b0, r_clr} < tlpt_pkg::CLR_LEAF_LIM);
                leaf_waddr = tlpt_pkg::t_leaf_addr'(r_clr);
                n_clr      = r_clr + 1'b1;
                if (r_clr == tlpt_pkg::CLR_LAST) begin
                    n_state = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_IDLE: begin
                // Launch the directory read with the incoming word
                if (start) begin
                    dir_re  = 1'b1;
                    n_state = tlpt_pkg::S_DIR;
                end
            end
            tlpt_pkg::S_DIR: begin
                n_strobe = 1'b1;
                n_status = tlpt_pkg::ST_OK;
                n_addr   = '0;
                n_state  = tlpt_pkg::S_IDLE;
                case (r_op)
                    tlpt_pkg::OP_MAP: begin
                        if (!w_dir_ok) begin
                            n_status = tlpt_pkg::ST_NOT_MAPPED;
                        end else if (w_dent.present) begin
                            leaf_we    = 1'b1;
                            leaf_wdata = w_map_data;
                        end else if (r_next >= tlpt_pkg::SLOT_LIM) begin
                            n_status = tlpt_pkg::ST_NO_SLOT;
                        end else begin
                            // Allocate the next table slot, then fill the leaf in it
                            dir_we          = 1'b1;
                            dir_wdata.slot  = tlpt_pkg::t_slot'(r_next);
                            dir_wdata.user  = r_flags[2];
                            dir_wdata.present = 1'b1;
                            n_next          = r_next + 1'b1;
                            leaf_we         = 1'b1;
                            leaf_waddr      = w_new_leaf_addr;
                            leaf_wdata      = w_map_data;
                        end
                    end
                    tlpt_pkg::OP_UNMAP: begin
                        if (!w_dir_ok || !w_dent.present) begin
                            n_status = tlpt_pkg::ST_NOT_MAPPED;
                        end else begin
                            leaf_we = 1'b1;
                        end
                    end
                    tlpt_pkg::OP_XLATE: begin
                        if (!w_dir_ok || !w_dent.present) begin
                            n_status = tlpt_pkg::ST_NOT_MAPPED;
                        end else begin
                            // Hold the result back through S_LEAF for the leaf read
                            leaf_re  = 1'b1;
                            n_strobe = 1'b0;
                            n_state  = tlpt_pkg::S_LEAF;
                        end
                    end
                    default: begin
                        // Unused code: no change, ok with zero address
                    end
                endcase
            end
            tlpt_pkg::S_LEAF: begin
                n_strobe = 1'b1;
                n_state  = tlpt_pkg::S_IDLE;
                if (leaf_rdata[0]) begin
                    n_status = tlpt_pkg::ST_OK;
                    n_addr   = (leaf_rdata[31:0] & tlpt_pkg::FRAME_MASK) |
                               {20'd0, r_va[11:0]};
                end else begin
                    n_status = tlpt_pkg::ST_NOT_MAPPED;
                    n_addr   = '0;
                end
            end
            default: begin
                n_state = tlpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tlpt_pkg::S_CLEAR;
            r_clr    <= '0;
            r_next   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_next   <= n_next;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_addr   <= n_addr;
        if (r_state == tlpt_pkg::S_IDLE && start) begin
            r_op    <= i_operation;
            r_va    <= i_virtual_address;
            r_pa    <= i_physical_address;
            r_flags <= i_entry_flags;
        end
    end

    assign o_strobe             = r_strobe;
    assign o_status             = r_status;
    assign o_translated_address = r_addr;

endmodule

### sim/tlpt_walk_checker.sv
// Watch both channels of the page table manager, predict every word and compare.
// Depends on tlpt_pkg for sizes and operation/status codes.
`timescale 1ns / 1ps

module tlpt_walk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_virtual_address,
    input  logic [35:0] i_physical_address,
    input  logic [11:0] i_entry_flags,
    input  logic        i_strobe,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_translated_address,
    input  logic        i_drain,
    output int          o_fail_count,
    output int          o_pending
);
    import tlpt_pkg::*;

    // Writable and user bits never reach an output, so keep present and slot only
    typedef struct packed {
        logic        present;
        logic [15:0] slot;
    } dir_slot_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] xaddr;
    } walk_word_t;

    dir_slot_t   dir_model  [DIR_DEPTH];
    logic [35:0] leaf_model [LEAF_DEPTH];
    int unsigned slots_used;
    walk_word_t  walk_due [$];
    int          fail_total;
    bit          drain_seen;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_total++;
    endtask

    // Apply one request to the model tables and return the word it answers with
    task automatic walk_tables(input logic [1:0] op, input logic [31:0] va,
                               input logic [35:0] pa, input logic [11:0] fl,
                               output walk_word_t w);
        int unsigned dsel;
        int unsigned dpos;
        int unsigned lpos;
        dir_slot_t   de;
        w.status = ST_OK;
        w.xaddr  = '0;
        if (op > OP_XLATE)
            return;
        dsel = va[31:30];
        if (dsel >= DIRECTORY_COUNT) begin
            w.status = ST_NOT_MAPPED;
            return;
        end
        dpos = dsel * ENTRIES_PER_TABLE + va[29:21];
        de   = dir_model[dpos];
        if (op == OP_MAP) begin
            if (!de.present) begin
                if (slots_used >= TABLE_SLOTS) begin
                    w.status = ST_NO_SLOT;
                    return;
                end
                de.present     = 1'b1;
                de.slot        = 16'(slots_used);
                dir_model[dpos] = de;
                slots_used++;
            end
            lpos = de.slot * ENTRIES_PER_TABLE + va[20:12];
            leaf_model[lpos] = pa | {24'b0, fl};
        end else if (!de.present) begin
            w.status = ST_NOT_MAPPED;
        end else begin
            lpos = de.slot * ENTRIES_PER_TABLE + va[20:12];
            if (op == OP_UNMAP)
                leaf_model[lpos] = '0;
            else if (!leaf_model[lpos][0])
                w.status = ST_NOT_MAPPED;
            else
                w.xaddr = (leaf_model[lpos][31:0] & FRAME_MASK) | {20'b0, va[11:0]};
        end
    endtask

    always @(posedge i_clk) begin
        walk_word_t due_w;
        if (!i_rst_n) begin
            for (int i = 0; i < DIR_DEPTH; i++)
                dir_model[i] = '0;
            for (int i = 0; i < LEAF_DEPTH; i++)
                leaf_model[i] = '0;
            slots_used = 0;
            walk_due.delete();
            fail_total = 0;
            drain_seen = 1'b0;
        end else begin
            // Check the result first; it always belongs to an older word
            if (i_strobe) begin
                if (walk_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result status %0d addr %h",
                                            i_status, i_translated_address));
                end else begin
                    due_w = walk_due.pop_front();
                    if (i_status !== due_w.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                i_status, due_w.status));
                    if (i_translated_address !== due_w.xaddr)
                        flag_mismatch($sformatf("translated address %h, want %h",
                                                i_translated_address, due_w.xaddr));
                end
            end
            if (i_start && !i_busy) begin
                walk_tables(i_operation, i_virtual_address, i_physical_address,
                            i_entry_flags, due_w);
                walk_due.push_back(due_w);
            end
            if (i_drain && !drain_seen) begin
                drain_seen = 1'b1;
                if (walk_due.size() != 0)
                    flag_mismatch($sformatf("%0d results never arrived", walk_due.size()));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= walk_due.size();
    end

endmodule

### sim/two_level_page_table_manager_core_test.sv
// Stimulus and verdict for the two-level page table manager core.
// Depends on tlpt_pkg, the core itself and tlpt_walk_checker.
`timescale 1ns / 1ps

module two_level_page_table_manager_core_test;
    import tlpt_pkg::*;

    // Spare operation code: the core must answer it with ok and touch nothing
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 550;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [31:0] i_virtual_address;
    logic [35:0] i_physical_address;
    logic [11:0] i_entry_flags;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_translated_address;
    logic        drain;
    int          fail_count;
    int          pending;

    // Up to 64 virtual addresses handed to map; reused to hit live directory entries
    logic [31:0] mapped_vas [$];

    two_level_page_table_manager_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_operation          (i_operation),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_entry_flags        (i_entry_flags),
        .o_strobe             (o_strobe),
        .o_status             (o_status),
        .o_translated_address (o_translated_address)
    );

    tlpt_walk_checker watch (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_operation          (i_operation),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_entry_flags        (i_entry_flags),
        .i_strobe             (o_strobe),
        .i_status             (o_status),
        .i_translated_address (o_translated_address),
        .i_drain              (drain),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Present one word and hold it until the core takes it (start high, busy low).
    // Busy is read right after the edge, so it is the value the core saw there.
    task automatic issue_word(input logic [1:0] op, input logic [31:0] va,
                              input logic [35:0] pa, input logic [11:0] fl);
        start              <= 1'b1;
        i_operation        <= op;
        i_virtual_address  <= va;
        i_physical_address <= pa;
        i_entry_flags      <= fl;
        do @(posedge i_clk); while (busy);
        if (op == OP_MAP && mapped_vas.size() < 64)
            mapped_vas.push_back(va);
    endtask

    // Drop start for the given gap; zero leaves it high for back-to-back words
    task automatic idle_for(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bias addresses toward live directory entries so map, unmap and translate
    // meet each other; keep a share fully random for the rest of the space
    function automatic logic [31:0] pick_va();
        int unsigned r;
        logic [31:0] v;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 50 && mapped_vas.size() > 0) begin
            base = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
            v[31:21] = base[31:21];
            if ($urandom_range(0, 1))
                v[20:12] = base[20:12];
        end else if (r < 75) begin
            case ($urandom_range(0, 3))
                0: v[29:21] = 9'h000;
                1: v[29:21] = 9'h001;
                2: v[29:21] = 9'h1FF;
                default: v[29:21] = 9'h0AA;
            endcase
        end
        return v;
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_MAP;
        if (r < 55)
            return OP_UNMAP;
        if (r < 95)
            return OP_XLATE;
        return OP_SPARE;
    endfunction

    initial begin
        logic [11:0] fl;
        logic [35:0] pa;
        bit          burst;
        int          waited;

        // Known values on every input before the first edge
        i_rst_n            <= 1'b0;
        start              <= 1'b0;
        i_operation        <= OP_MAP;
        i_virtual_address  <= '0;
        i_physical_address <= '0;
        i_entry_flags      <= '0;
        drain              <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the clearing sweep after reset is absorbed by issue_word
        issue_word(OP_XLATE, 32'h0000_0000, '0, '0);           // directory absent
        issue_word(OP_UNMAP, 32'h0000_0000, '0, '0);           // directory absent
        issue_word(OP_MAP,   32'h0000_0000, 36'hF_FFFF_FFFF, 12'hFFF);
        issue_word(OP_XLATE, 32'h0000_0FFF, '0, '0);           // wide leaf bits masked
        issue_word(OP_MAP,   32'hFFFF_FFFF, 36'h0, 12'h000);   // leaf without present
        issue_word(OP_XLATE, 32'hFFFF_FFFF, '0, '0);           // leaf not present
        idle_for(2);
        issue_word(OP_UNMAP, 32'h0000_0000, '0, '0);
        issue_word(OP_XLATE, 32'h0000_0123, '0, '0);           // cleared leaf
        issue_word(OP_UNMAP, 32'h0000_1000, '0, '0);           // absent leaf, dir present
        issue_word(OP_SPARE, 32'hC0DE_F00D, 36'hA_5A5A_5A5A, 12'hA5A);
        issue_word(OP_MAP,   32'h4020_0000, 36'h8_1234_5000, 12'h005);
        issue_word(OP_XLATE, 32'h4020_0ABC, '0, '0);
        issue_word(OP_MAP,   32'h4020_1000, 36'h0_0000_0000, 12'h001); // same table
        issue_word(OP_XLATE, 32'h4020_1FFF, '0, '0);
        idle_for(1);
        issue_word(OP_MAP,   32'h8000_0000, 36'h7_FFFF_F000, 12'h003);
        issue_word(OP_XLATE, 32'h8000_0000, '0, '0);
        issue_word(OP_SPARE, 32'h0000_0000, '0, '0);
        issue_word(OP_XLATE, 32'hBFFF_FFFF, '0, '0);           // dir 2 entry never mapped

        // Random part; alternate stretches of back-to-back words and gapped words
        burst = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            fl = 12'($urandom);
            if ($urandom_range(0, 99) < 80)
                fl[0] = 1'b1;
            pa = {4'($urandom), 32'($urandom)};
            issue_word(pick_op(), pick_va(), pa, fl);
            if (!burst)
                idle_for(pick_gap());
        end
        start <= 1'b0;

        // Drain: wait for every due result, then let the last one settle before the check
        waited = 0;
        while (pending != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        drain <= 1'b1;
        repeat (3) @(posedge i_clk);

        if (fail_count == 0)
            $display("[two_level_page_table_manager_core] OK");
        else
            $display("[two_level_page_table_manager_core] ERROR");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #3_000_000;
        $display("[two_level_page_table_manager_core] ERROR");
        $finish;
    end

endmodule
